@@ hdl/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the pressure sensor compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

	// calibration words and model select as held by the register file
	typedef struct packed {
		logic [15:0] c1;         // pressure sensitivity
		logic [15:0] c2;         // pressure offset
		logic [15:0] c3;         // temp coefficient of sensitivity
		logic [15:0] c4;         // temp coefficient of offset
		logic [15:0] c5;         // reference temperature / 256
		logic [15:0] c6;         // temp coefficient of temperature
		logic        model_2bar; // 1: 2 bar rules, 0: 30 bar rules
	} psc_cfg_t;

	// register indexes on the configuration port
	localparam logic [2:0] REG_PRESS_SENS  = 3'd0;
	localparam logic [2:0] REG_PRESS_OFFS  = 3'd1;
	localparam logic [2:0] REG_SENS_TEMP   = 3'd2;
	localparam logic [2:0] REG_OFFS_TEMP   = 3'd3;
	localparam logic [2:0] REG_REF_TEMP    = 3'd4;
	localparam logic [2:0] REG_TEMP_SENS   = 3'd5;
	localparam logic [2:0] REG_MODEL       = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int RAW_W      = 24;
	localparam int RES_W      = 32;

	// number of pipeline stages, the last one is the result register
	localparam int NUM_STAGES = 10;

endpackage

`default_nettype wire

@@ hdl/psc_cfg.sv @@
// ----------------------------------------------------------------------------
// psc_cfg
// Calibration register file: six 16-bit calibration words and the model select.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [psc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [psc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output psc_pkg::psc_cfg_t                      coef
);

	psc_pkg::psc_cfg_t coef_q;

	// writes complete in the cycle they are offered
	assign cfg_ready = 1'b1;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				psc_pkg::REG_PRESS_SENS: coef_q.c1 <= cfg_data;
				psc_pkg::REG_PRESS_OFFS: coef_q.c2 <= cfg_data;
				psc_pkg::REG_SENS_TEMP:  coef_q.c3 <= cfg_data;
				psc_pkg::REG_OFFS_TEMP:  coef_q.c4 <= cfg_data;
				psc_pkg::REG_REF_TEMP:   coef_q.c5 <= cfg_data;
				psc_pkg::REG_TEMP_SENS:  coef_q.c6 <= cfg_data;
				psc_pkg::REG_MODEL:      coef_q.model_2bar <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

@@ hdl/pressure_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Second-order temperature compensation of raw barometric sensor conversions.
// ----------------------------------------------------------------------------
// Takes one raw pressure/temperature conversion pair per clock while the
// input is not stalled and returns the compensated pressure and the
// temperature in 0.01 degC, offered from the stage 10 result register. The
// work runs through a ten-stage pipeline; the pressure product (24-bit raw
// value times a 42-bit sensitivity) is split into two partial products over
// its own stages. Each stage holds its item until the next one frees up, so
// empty stages fill while the result waits and a full pipeline holds ten
// items. The user must write calibration words and the model select through
// the configuration port only while no item is in flight; the block does not
// enforce this. Results keep the low 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_sensor_compensation (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [psc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [psc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// raw conversion pair
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	input  wire logic [psc_pkg::RAW_W-1:0]         raw_pressure,
	input  wire logic [psc_pkg::RAW_W-1:0]         raw_temperature,
	// compensated result
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic signed [psc_pkg::RES_W-1:0]       pressure_out,
	output logic signed [psc_pkg::RES_W-1:0]       temperature_out
);

	localparam int NS = psc_pkg::NUM_STAGES;

	psc_pkg::psc_cfg_t coef;

	// signed divide by 2^k, rounding toward zero
	function automatic logic signed [47:0] sdiv_pow2(input logic signed [47:0] x,
			input logic [5:0] k);
		logic signed [47:0] bias;
		bias = x[47] ? ((48'sd1 <<< k) - 48'sd1) : 48'sd0;
		return (x + bias) >>> k;
	endfunction

	psc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// ------------------------------------------------------------------
	// stage flow control
	// ------------------------------------------------------------------
	logic [NS:1] vld_q;
	logic [NS:1] adv;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		adv[NS] = !vld_q[NS] || !result_stall;
		for (int i = NS - 1; i >= 1; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= sample_valid;
			for (int i = 2; i <= NS; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign sample_stall = !adv[1];
	assign result_valid = vld_q[NS];

	// ------------------------------------------------------------------
	// stage 1: temperature difference from reference
	// ------------------------------------------------------------------
	logic signed [24:0] dt_s1;
	logic        [23:0] d1_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.c5, 8'h00});
			d1_s1 <= raw_pressure;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: coefficient products and dt squared
	// ------------------------------------------------------------------
	logic signed [41:0] c3dt_s2, c4dt_s2, c6dt_s2;
	logic        [47:0] dtsq_s2;
	logic        [23:0] d1_s2;
	logic signed [49:0] dtsq_full;

	assign dtsq_full = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			c3dt_s2 <= $signed({1'b0, coef.c3}) * dt_s1;
			c4dt_s2 <= $signed({1'b0, coef.c4}) * dt_s1;
			c6dt_s2 <= $signed({1'b0, coef.c6}) * dt_s1;
			dtsq_s2 <= dtsq_full[47:0];
			d1_s2   <= d1_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: first-order sens, off, temperature and second-order ti
	// ------------------------------------------------------------------
	logic signed [47:0] c3dt_x, c4dt_x, c6dt_x;
	logic signed [47:0] sens_a, off_a, sens_b, off_b, sens_sum, off_sum;
	logic signed [47:0] dtemp_full, v_full;
	logic        [51:0] ti_2bar_m;
	logic        [49:0] ti_low_m;
	logic        [16:0] ti_sel;
	logic signed [37:0] sens_s3, off_s3;
	logic signed [18:0] dtemp_s3, v_s3;
	logic        [16:0] ti_s3;
	logic               cold_s3, vcold_s3;
	logic        [23:0] d1_s3;

	assign c3dt_x = {{6{c3dt_s2[41]}}, c3dt_s2};
	assign c4dt_x = {{6{c4dt_s2[41]}}, c4dt_s2};
	assign c6dt_x = {{6{c6dt_s2[41]}}, c6dt_s2};

	always_comb begin
		if (coef.model_2bar) begin
			sens_a = sdiv_pow2(c3dt_x, 6'd7);
			off_a  = sdiv_pow2(c4dt_x, 6'd6);
			sens_b = $signed({16'h0000, coef.c1, 16'h0000});
			off_b  = $signed({15'd0, coef.c2, 17'd0});
		end else begin
			sens_a = sdiv_pow2(c3dt_x, 6'd8);
			off_a  = sdiv_pow2(c4dt_x, 6'd7);
			sens_b = $signed({17'd0, coef.c1, 15'd0});
			off_b  = $signed({16'h0000, coef.c2, 16'h0000});
		end
	end

	assign sens_sum   = sens_a + sens_b;
	assign off_sum    = off_a + off_b;
	assign dtemp_full = sdiv_pow2(c6dt_x, 6'd23);
	assign v_full     = dtemp_full + 48'sd3500;

	// 11*dt^2 and 3*dt^2 by shift and add
	assign ti_2bar_m = ({4'h0, dtsq_s2} << 3) + ({4'h0, dtsq_s2} << 1) + {4'h0, dtsq_s2};
	assign ti_low_m  = ({2'b00, dtsq_s2} << 1) + {2'b00, dtsq_s2};

	// ti by model and temperature band (cold means below 20 degC)
	always_comb begin
		if (coef.model_2bar) begin
			ti_sel = dtemp_full[47] ? ti_2bar_m[51:35] : 17'd0;
		end else if (dtemp_full[47]) begin
			ti_sel = ti_low_m[49:33];
		end else begin
			ti_sel = {5'b00000, dtsq_s2[47:36]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			sens_s3  <= sens_sum[37:0];
			off_s3   <= off_sum[37:0];
			dtemp_s3 <= dtemp_full[18:0];
			v_s3     <= v_full[18:0];
			ti_s3    <= ti_sel;
			cold_s3  <= dtemp_full[47];
			vcold_s3 <= (dtemp_full < -48'sd3500);
			d1_s3    <= d1_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: squares for the offset and sensitivity corrections
	// ------------------------------------------------------------------
	logic signed [37:0] dsq_full, vsq_full;
	logic        [34:0] dsq_s4;
	logic        [35:0] vsq_s4;
	logic signed [20:0] temp_s4;
	logic signed [37:0] sens_s4, off_s4;
	logic               cold_s4, vcold_s4;
	logic        [23:0] d1_s4;

	assign dsq_full = dtemp_s3 * dtemp_s3;
	assign vsq_full = v_s3 * v_s3;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			dsq_s4   <= dsq_full[34:0];
			vsq_s4   <= vsq_full[35:0];
			temp_s4  <= $signed({{2{dtemp_s3[18]}}, dtemp_s3}) + 21'sd2000
				- $signed({4'h0, ti_s3});
			sens_s4  <= sens_s3;
			off_s4   <= off_s3;
			cold_s4  <= cold_s3;
			vcold_s4 <= vcold_s3;
			d1_s4    <= d1_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: offset and sensitivity corrections
	// ------------------------------------------------------------------
	logic [40:0] s_x, w_x, s31, s63, s3, s5, w7, w4;
	logic [40:0] offi, sensi;
	logic [40:0] offi_s5, sensi_s5;
	logic signed [37:0] sens_s5, off_s5;
	logic signed [20:0] temp_s5;
	logic        [23:0] d1_s5;

	assign s_x = {6'h00, dsq_s4};
	assign w_x = {5'h00, vsq_s4};
	assign s31 = (s_x << 5) - s_x;
	assign s63 = (s_x << 6) - s_x;
	assign s3  = (s_x << 1) + s_x;
	assign s5  = (s_x << 2) + s_x;
	assign w7  = (w_x << 3) - w_x;
	assign w4  = w_x << 2;

	always_comb begin
		if (coef.model_2bar) begin
			offi  = cold_s4 ? (s31 >> 3) : 41'd0;
			sensi = cold_s4 ? (s63 >> 5) : 41'd0;
		end else if (cold_s4) begin
			// very cold band adds a second term
			offi  = (s3 >> 1) + (vcold_s4 ? w7 : 41'd0);
			sensi = (s5 >> 3) + (vcold_s4 ? w4 : 41'd0);
		end else begin
			offi  = s_x >> 4;
			sensi = 41'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			offi_s5  <= offi;
			sensi_s5 <= sensi;
			sens_s5  <= sens_s4;
			off_s5   <= off_s4;
			temp_s5  <= temp_s4;
			d1_s5    <= d1_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: corrected sensitivity and offset
	// ------------------------------------------------------------------
	logic signed [41:0] sens_c_s6, off_c_s6;
	logic signed [20:0] temp_s6;
	logic        [23:0] d1_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			sens_c_s6 <= $signed({{4{sens_s5[37]}}, sens_s5}) - $signed({1'b0, sensi_s5});
			off_c_s6  <= $signed({{4{off_s5[37]}}, off_s5}) - $signed({1'b0, offi_s5});
			temp_s6   <= temp_s5;
			d1_s6     <= d1_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 7: pressure product as two partial products
	// ------------------------------------------------------------------
	logic        [44:0] pp_lo_s7;
	logic signed [45:0] pp_hi_s7;
	logic               xneg_s7;
	logic signed [41:0] off_c_s7;
	logic signed [20:0] temp_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			pp_lo_s7 <= {21'd0, d1_s6} * {24'h000000, sens_c_s6[20:0]};
			pp_hi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens_c_s6[41:21]);
			xneg_s7  <= sens_c_s6[41] && (d1_s6 != 24'd0);
			off_c_s7 <= off_c_s6;
			temp_s7  <= temp_s6;
		end
	end

	// ------------------------------------------------------------------
	// stage 8: product / 2^21 toward zero
	// ------------------------------------------------------------------
	logic signed [45:0] tr_s8;
	logic signed [41:0] off_c_s8;
	logic signed [20:0] temp_s8;
	logic               round_up;

	assign round_up = xneg_s7 && (|pp_lo_s7[20:0]);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			tr_s8    <= pp_hi_s7 + $signed({22'd0, pp_lo_s7[44:21]})
				+ $signed({45'd0, round_up});
			off_c_s8 <= off_c_s7;
			temp_s8  <= temp_s7;
		end
	end

	// ------------------------------------------------------------------
	// stage 9: subtract offset
	// ------------------------------------------------------------------
	logic signed [47:0] q_s9;
	logic signed [20:0] temp_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			q_s9    <= $signed({{2{tr_s8[45]}}, tr_s8}) - $signed({{6{off_c_s8[41]}}, off_c_s8});
			temp_s9 <= temp_s8;
		end
	end

	// ------------------------------------------------------------------
	// stage 10: final scale and result register
	// ------------------------------------------------------------------
	logic signed [47:0] p_full;
	logic signed [31:0] press_s10, temp_s10;

	assign p_full = sdiv_pow2(q_s9, coef.model_2bar ? 6'd15 : 6'd13);

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			press_s10 <= p_full[31:0];
			temp_s10  <= {{11{temp_s9[20]}}, temp_s9};
		end
	end

	assign pressure_out    = press_s10;
	assign temperature_out = temp_s10;

endmodule

`default_nettype wire
